// ===== hw/rtl/aobp_pkg.sv =====
// ----------------------------------------------------------------------------
// aobp_pkg
// Shared types and constants for the alpha-over pixel blend pipeline.
// ----------------------------------------------------------------------------
package aobp_pkg;

    localparam int PIX_W     = 8;
    localparam int NUM_W     = 2 * PIX_W;
    localparam int PROD_W    = 3 * PIX_W;
    localparam int NUM_CHAN  = 3;

    localparam int FRONT_STAGES = 3;
    localparam int DIV_BITS     = 2;
    localparam int DIV_STAGES   = PIX_W / DIV_BITS;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

    localparam logic [PIX_W-1:0] FULL_ALPHA = 8'd255;

    // color channel order inside the numerator and quotient arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_argb;

    // per-pixel decision and bypass data that rides alongside the divider
    typedef struct packed {
        t_argb            bypass;
        logic [PIX_W-1:0] t_alpha;
        logic             blend;
        logic             written;
    } t_side;

    typedef logic [NUM_CHAN-1:0][NUM_W-1:0] t_chan_num;
    typedef logic [NUM_CHAN-1:0][PIX_W-1:0] t_chan_quo;
    typedef logic [FRONT_STAGES-1:0]        t_front_en;
    typedef logic [DIV_STAGES-1:0]          t_div_en;

endpackage

// ===== hw/rtl/alpha_over_blend_pixel.sv =====
// ----------------------------------------------------------------------------
// alpha_over_blend_pixel
// Draws one straight-alpha ARGB source pixel over a destination pixel and
// returns the new destination pixel. The block takes one pixel pair per
// clock unless the pipeline is full and the output waits: three stages
// compute the case, the result alpha and the channel numerators, four
// stages run the radix-4 channel dividers, and one stage holds the output.
// Every stage has its own valid bit and fills a bubble while the output
// waits, so o_ready only drops once all eight stages hold a pixel. A
// transparent source returns the destination with o_pixel_written low.
// ----------------------------------------------------------------------------
module alpha_over_blend_pixel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    input  logic [7:0] i_dst_alpha,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_alpha,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic       o_pixel_written
);
    import aobp_pkg::*;

    logic [NUM_STAGES-1:0] w_en;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;

    t_argb     w_src, w_dst;
    t_side     w_front_side;
    t_chan_num w_num;
    t_chan_quo w_quo;

    t_side     r_side [DIV_STAGES];
    t_argb     r_out;
    logic      r_written;
    t_argb     n_out;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES-2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_src = '{alpha: i_src_alpha, red: i_src_red, green: i_src_green,
                     blue: i_src_blue};
    assign w_dst = '{alpha: i_dst_alpha, red: i_dst_red, green: i_dst_green,
                     blue: i_dst_blue};

    aobp_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en[FRONT_STAGES-1:0]),
        .i_src  (w_src),
        .i_dst  (w_dst),
        .o_side (w_front_side),
        .o_num  (w_num)
    );

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        aobp_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
            .i_num (w_num[c]),
            .i_t   (w_front_side.t_alpha),
            .o_quo (w_quo[c])
        );
    end

    // decision and bypass pixel ride alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en[FRONT_STAGES]) begin
            r_side[0] <= w_front_side;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (w_en[FRONT_STAGES+k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_comb begin
        if (r_side[DIV_STAGES-1].blend) begin
            n_out.alpha = r_side[DIV_STAGES-1].t_alpha;
            n_out.red   = w_quo[CH_RED];
            n_out.green = w_quo[CH_GREEN];
            n_out.blue  = w_quo[CH_BLUE];
        end else begin
            n_out = r_side[DIV_STAGES-1].bypass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NUM_STAGES-1]) begin
            r_out     <= n_out;
            r_written <= r_side[DIV_STAGES-1].written;
        end
    end

    assign o_ready         = w_en[0];
    assign o_valid         = r_vld[NUM_STAGES-1];
    assign o_out_alpha     = r_out.alpha;
    assign o_out_red       = r_out.red;
    assign o_out_green     = r_out.green;
    assign o_out_blue      = r_out.blue;
    assign o_pixel_written = r_written;

endmodule

// ===== hw/rtl/aobp_front.sv =====
// ----------------------------------------------------------------------------
// aobp_front
// First three stages: case decision and weight products, result alpha and
// channel products, then the per-channel numerators fed to the dividers.
// ----------------------------------------------------------------------------
module aobp_front (
    input  logic              i_clk,
    input  aobp_pkg::t_front_en i_en,
    input  aobp_pkg::t_argb   i_src,
    input  aobp_pkg::t_argb   i_dst,
    output aobp_pkg::t_side   o_side,
    output aobp_pkg::t_chan_num o_num
);
    import aobp_pkg::*;

    // stage 0
    logic [NUM_W-1:0] n0_prod, n0_dw;
    t_side            n0_side;
    logic [PIX_W-1:0] r0_sa;
    logic [PIX_W-1:0] r0_da;
    t_argb            r0_src, r0_dst;
    logic [NUM_W-1:0] r0_prod, r0_dw;
    t_side            r0_side;

    // stage 1
    logic [NUM_W-1:0]  n1_q_sum;
    logic [PIX_W:0]    n1_t;
    logic [NUM_W-1:0]  n1_scale;
    t_side             n1_side;
    t_side             r1_side;
    logic [PROD_W-1:0] r1_dprod [NUM_CHAN];
    logic [PROD_W-1:0] r1_sprod [NUM_CHAN];

    // stage 2
    t_side             r2_side;
    t_chan_num         r2_num;

    logic [PIX_W-1:0]  w_src_ch [NUM_CHAN];
    logic [PIX_W-1:0]  w_dst_ch [NUM_CHAN];

    always_comb begin
        n0_prod = NUM_W'(i_src.alpha) * NUM_W'(i_dst.alpha);
        n0_dw   = NUM_W'(FULL_ALPHA - i_src.alpha) * NUM_W'(i_dst.alpha);
        n0_side.written = (i_src.alpha != '0);
        n0_side.blend   = (i_src.alpha != '0) && (i_src.alpha != FULL_ALPHA)
                          && (i_dst.alpha != '0);
        n0_side.bypass  = (i_src.alpha == '0) ? i_dst : i_src;
        n0_side.t_alpha = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_sa   <= i_src.alpha;
            r0_da   <= i_dst.alpha;
            r0_src  <= i_src;
            r0_dst  <= i_dst;
            r0_prod <= n0_prod;
            r0_dw   <= n0_dw;
            r0_side <= n0_side;
        end
    end

    assign w_src_ch[CH_RED]   = r0_src.red;
    assign w_src_ch[CH_GREEN] = r0_src.green;
    assign w_src_ch[CH_BLUE]  = r0_src.blue;
    assign w_dst_ch[CH_RED]   = r0_dst.red;
    assign w_dst_ch[CH_GREEN] = r0_dst.green;
    assign w_dst_ch[CH_BLUE]  = r0_dst.blue;

    // floor(p/255) for p up to 255*255 is (p + (p >> 8) + 1) >> 8
    always_comb begin
        n1_q_sum = r0_prod + NUM_W'(r0_prod[NUM_W-1:PIX_W]) + NUM_W'(1);
        n1_t     = (PIX_W+1)'(r0_sa) + (PIX_W+1)'(r0_da)
                   - (PIX_W+1)'(n1_q_sum[NUM_W-1:PIX_W]);
        n1_scale = {r0_sa, {PIX_W{1'b0}}} - NUM_W'(r0_sa);
        n1_side         = r0_side;
        n1_side.t_alpha = n1_t[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_side <= n1_side;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r1_dprod[c] <= PROD_W'(w_dst_ch[c]) * PROD_W'(r0_dw);
                r1_sprod[c] <= PROD_W'(w_src_ch[c]) * PROD_W'(n1_scale);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_side <= r1_side;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r2_num[c] <= NUM_W'((r1_dprod[c] + r1_sprod[c]) >> PIX_W);
            end
        end
    end

    assign o_side = r2_side;
    assign o_num  = r2_num;

endmodule

// ===== hw/rtl/aobp_div.sv =====
// ----------------------------------------------------------------------------
// aobp_div
// Pipelined restoring divider for one channel: 16-bit numerator by the
// 8-bit result alpha, two quotient bits per stage.
// ----------------------------------------------------------------------------
module aobp_div (
    input  logic              i_clk,
    input  aobp_pkg::t_div_en i_en,
    input  logic [aobp_pkg::NUM_W-1:0] i_num,
    input  logic [aobp_pkg::PIX_W-1:0] i_t,
    output logic [aobp_pkg::PIX_W-1:0] o_quo
);
    import aobp_pkg::*;

    logic [PIX_W-1:0] r_rem [DIV_STAGES];
    logic [PIX_W-1:0] r_low [DIV_STAGES];
    logic [PIX_W-1:0] r_quo [DIV_STAGES];
    logic [PIX_W-1:0] r_t   [DIV_STAGES];
    logic [PIX_W-1:0] n_rem [DIV_STAGES];
    logic [PIX_W-1:0] n_low [DIV_STAGES];
    logic [PIX_W-1:0] n_quo [DIV_STAGES];
    logic [PIX_W-1:0] n_t   [DIV_STAGES];

    // one compare-subtract; the partial remainder stays below the divisor
    function automatic logic [PIX_W:0] div_step(
        input logic [PIX_W-1:0] rem,
        input logic             nb,
        input logic [PIX_W-1:0] divisor
    );
        logic [PIX_W:0] trial;
        logic [PIX_W:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            return {1'b1, diff[PIX_W-1:0]};
        end
        return {1'b0, trial[PIX_W-1:0]};
    endfunction

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [PIX_W-1:0]    w_rem_in, w_low_in, w_quo_in, w_t_in;
        logic [PIX_W-1:0]    w_rem_out;
        logic [DIV_BITS-1:0] w_qb;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num[NUM_W-1:PIX_W];
            assign w_low_in = i_num[PIX_W-1:0];
            assign w_quo_in = '0;
            assign w_t_in   = i_t;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_low_in = r_low[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_t_in   = r_t[k-1];
        end

        always_comb begin : b_step
            logic [PIX_W-1:0] rem_v;
            logic [PIX_W:0]   res;
            rem_v = w_rem_in;
            res   = '0;
            w_qb  = '0;
            for (int j = 0; j < DIV_BITS; j++) begin
                res = div_step(rem_v, w_low_in[PIX_W-1-j], w_t_in);
                w_qb[DIV_BITS-1-j] = res[PIX_W];
                rem_v = res[PIX_W-1:0];
            end
            w_rem_out = rem_v;
        end

        assign n_rem[k] = w_rem_out;
        assign n_low[k] = {w_low_in[PIX_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
        assign n_quo[k] = {w_quo_in[PIX_W-DIV_BITS-1:0], w_qb};
        assign n_t[k]   = w_t_in;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_t[k]   <= n_t[k];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

// ===== bench/alpha_over_blend_pixel_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpha_over_blend_pixel_tb
// Self-checking bench for the straight-alpha over blend. A short table of
// corner pixels is followed by randomized pixel pairs across four traffic
// phases; each result is compared to a typed or locally blended pixel.
// ----------------------------------------------------------------------------
module alpha_over_blend_pixel_tb;
    import aobp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int PIPE_LATENCY = 8;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_DIRECTED = 19;
    localparam int PEND_DEPTH   = 1024;

    typedef struct packed {
        t_argb pix;
        logic  written;
    } t_blend_result;

    typedef struct packed {
        t_argb src;
        t_argb dst;
        logic  typed;
        t_argb want_pix;
        logic  want_written;
    } t_blend_case;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_src_alpha = '0;
    logic [7:0] i_src_red = '0;
    logic [7:0] i_src_green = '0;
    logic [7:0] i_src_blue = '0;
    logic [7:0] i_dst_alpha = '0;
    logic [7:0] i_dst_red = '0;
    logic [7:0] i_dst_green = '0;
    logic [7:0] i_dst_blue = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_alpha;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic       o_pixel_written;

    // expectation travels with the payload so the monitor picks it up on accept
    t_blend_result held_result = '0;
    t_blend_result pending_pixels [PEND_DEPTH];
    int            pend_head = 0;
    int            pend_tail = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            fail_count = 0;
    int            cycle_count = 0;

    // AARRGGBB
    t_blend_case directed_cases [NUM_DIRECTED] = '{
        '{32'h00FFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{32'h00123456, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{32'h00AA55AA, 32'h5AC33CA5, 1'b1, 32'h5AC33CA5, 1'b0},
        '{32'hFF123456, 32'hC8FF0080, 1'b1, 32'hFF123456, 1'b1},
        '{32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b1},
        '{32'hFF000000, 32'hFFFFFFFF, 1'b1, 32'hFF000000, 1'b1},
        '{32'h01FF00AA, 32'h0055AAFF, 1'b1, 32'h01FF00AA, 1'b1},
        '{32'h80A55A0F, 32'h00FFFFFF, 1'b1, 32'h80A55A0F, 1'b1},
        '{32'hFEFFFFFF, 32'h00000000, 1'b1, 32'hFEFFFFFF, 1'b1},
        '{32'h01FFFFFF, 32'hFF000000, 1'b0, 32'h0, 1'b0},
        '{32'h01000000, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{32'hFEFFFFFF, 32'h01000000, 1'b0, 32'h0, 1'b0},
        '{32'hFE000000, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{32'hFEFFFFFF, 32'hFEFFFFFF, 1'b0, 32'h0, 1'b0},
        '{32'h0100FF00, 32'h01FF00FF, 1'b0, 32'h0, 1'b0},
        '{32'h80AA55AA, 32'h8055AA55, 1'b0, 32'h0, 1'b0},
        '{32'h7FFF8001, 32'hC8017FFE, 1'b0, 32'h0, 1'b0},
        '{32'h40102030, 32'hFFF0E0D0, 1'b0, 32'h0, 1'b0},
        '{32'hC0FFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0}
    };

    alpha_over_blend_pixel dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_src_alpha     (i_src_alpha),
        .i_src_red       (i_src_red),
        .i_src_green     (i_src_green),
        .i_src_blue      (i_src_blue),
        .i_dst_alpha     (i_dst_alpha),
        .i_dst_red       (i_dst_red),
        .i_dst_green     (i_dst_green),
        .i_dst_blue      (i_dst_blue),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_alpha     (o_out_alpha),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_pixel_written (o_pixel_written)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [7:0] mix_channel(input int unsigned s, input int unsigned d,
                                               input int unsigned dst_w, input int unsigned src_w,
                                               input int unsigned t);
        int unsigned num;
        num = (d * dst_w + src_w * s) >> 8;
        return 8'((num / t) & 32'hFF);
    endfunction

    // source drawn over destination, straight alpha
    function automatic t_blend_result blend_over(input t_argb src, input t_argb dst);
        t_blend_result res;
        int unsigned   sa, da, t, dst_w, src_w;
        sa = src.alpha;
        da = dst.alpha;
        if (sa == 0) begin
            res.pix     = dst;
            res.written = 1'b0;
        end else if (src.alpha == FULL_ALPHA || da == 0) begin
            res.pix     = src;
            res.written = 1'b1;
        end else begin
            t     = sa + da - (sa * da) / 255;
            dst_w = (255 - sa) * da;
            src_w = 255 * sa;
            res.pix.alpha = 8'(t & 32'hFF);
            res.pix.red   = mix_channel(src.red, dst.red, dst_w, src_w, t);
            res.pix.green = mix_channel(src.green, dst.green, dst_w, src_w, t);
            res.pix.blue  = mix_channel(src.blue, dst.blue, dst_w, src_w, t);
            res.written   = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return 8'h00;
        end else if (roll < 30) begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    // mostly real blends, plus the transparent, opaque and empty-destination paths
    task automatic make_pixel_pair(output t_argb src, output t_argb dst);
        int unsigned roll;
        roll = $urandom_range(99);
        src = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        dst = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        if (roll < 15) begin
            src.alpha = 8'h00;
        end else if (roll < 28) begin
            src.alpha = FULL_ALPHA;
        end else if (roll < 38) begin
            dst.alpha = 8'h00;
        end else if (roll < 45) begin
            // leave both alphas as drawn
        end else begin
            src.alpha = 8'($urandom_range(254, 1));
            dst.alpha = 8'($urandom_range(255, 1));
        end
    endtask

    task automatic send_pixel(input t_argb src, input t_argb dst, input t_blend_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_src_alpha <= src.alpha;
        i_src_red   <= src.red;
        i_src_green <= src.green;
        i_src_blue  <= src.blue;
        i_dst_alpha <= dst.alpha;
        i_dst_red   <= dst.red;
        i_dst_green <= dst.green;
        i_dst_blue  <= dst.blue;
        held_result <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    task automatic check_byte(input string field, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result check first, then log the transaction accepted at this edge
    always @(posedge i_clk) begin
        t_blend_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pend_head == pend_tail) begin
                    $error("unexpected result transaction: alpha %0d red %0d green %0d blue %0d",
                           o_out_alpha, o_out_red, o_out_green, o_out_blue);
                    fail_count++;
                end else begin
                    want = pending_pixels[pend_head];
                    pend_head++;
                    check_byte("out_alpha", want.pix.alpha, o_out_alpha);
                    check_byte("out_red", want.pix.red, o_out_red);
                    check_byte("out_green", want.pix.green, o_out_green);
                    check_byte("out_blue", want.pix.blue, o_out_blue);
                    check_byte("pixel_written", {7'd0, want.written}, {7'd0, o_pixel_written});
                end
            end
            if (i_valid && o_ready) begin
                if (pend_tail < PEND_DEPTH) begin
                    pending_pixels[pend_tail] = held_result;
                    pend_tail++;
                end else begin
                    $error("expected-result store overflow");
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_argb         src, dst;
        t_blend_result want;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            src = directed_cases[i].src;
            dst = directed_cases[i].dst;
            if (directed_cases[i].typed) begin
                want.pix     = directed_cases[i].want_pix;
                want.written = directed_cases[i].want_written;
            end else begin
                want = blend_over(src, dst);
            end
            send_pixel(src, dst, want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case (i / (RANDOM_ITEMS / 4))
                0:       set_idling(0, 0);
                1:       set_idling(62, 0);
                2:       set_idling(0, 62);
                default: set_idling(8, 8);
            endcase
            make_pixel_pair(src, dst);
            send_pixel(src, dst, blend_over(src, dst));
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (pend_head != pend_tail) @(posedge i_clk);
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);

        if (fail_count == 0 && pend_head == pend_tail) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
